// ----- src/idl_pkg.sv -----
package idl_pkg;

	// Table geometry and field widths.
	localparam int TABLE_ENTRIES = 16;
	localparam int SAMPLE_BITS   = 10;
	localparam int CAL_STORED    = 16;
	localparam int CAL_COUNT     = (TABLE_ENTRIES < CAL_STORED) ? TABLE_ENTRIES : CAL_STORED;
	localparam int CAL_W         = 10;
	localparam int CMP_W         = (SAMPLE_BITS > CAL_W) ? SAMPLE_BITS : CAL_W;
	localparam int IDX_W         = (CAL_COUNT > 1) ? $clog2(CAL_COUNT) : 1;
	localparam int NUM_W         = CMP_W + 3;
	localparam int DIST_W        = 7;
	localparam int FRAC_W        = 3;
	localparam int STEP_CM       = 5;
	localparam int IN_TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W   = ((DIST_W + 7) / 8) * 8;

	localparam logic [DIST_W-1:0] STEP_DIST = DIST_W'(STEP_CM);
	localparam logic [DIST_W-1:0] SAT_DIST  = DIST_W'(STEP_CM * CAL_COUNT);

	// Sensor readings at 5, 10, 15, ... cm, strictly descending.
	localparam logic [CAL_W-1:0] CAL_TABLE [CAL_STORED] = '{
		10'd1023, 10'd730, 10'd570, 10'd450, 10'd390, 10'd340, 10'd300, 10'd260,
		10'd240,  10'd200, 10'd180, 10'd170, 10'd160, 10'd155, 10'd150, 10'd145
	};

	// Result of the table search, carried from the first stage.
	typedef struct packed {
		logic                   found;
		logic [IDX_W-1:0]       idx;
		logic [SAMPLE_BITS-1:0] sample;
	} search_t;

endpackage

// ----- src/idl_search.sv -----
module idl_search (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [idl_pkg::SAMPLE_BITS-1:0] in_sample,
	output logic                     valid_s1,
	input  logic                     ready_dn,
	output idl_pkg::search_t         data_s1
);
	import idl_pkg::*;

	logic [CAL_COUNT-1:0] hit;
	logic                 found;
	logic [IDX_W-1:0]     idx;
	logic                 adv;

	// Compare the sample against every table entry in parallel.
	always_comb begin
		for (int k = 0; k < CAL_COUNT; k++) begin
			hit[k] = CMP_W'(CAL_TABLE[k]) < CMP_W'(in_sample);
		end
	end

	// The first entry below the sample wins.
	always_comb begin
		found = |hit;
		idx   = '0;
		for (int k = CAL_COUNT - 1; k >= 0; k--) begin
			if (hit[k]) begin
				idx = IDX_W'(k);
			end
		end
	end

	assign adv      = !valid_s1 || ready_dn;
	assign in_ready = adv;

	// Stage 1 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			data_s1.found  <= found;
			data_s1.idx    <= idx;
			data_s1.sample <= in_sample;
		end
	end

endmodule

// ----- src/idl_interp.sv -----
module idl_interp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s1,
	output logic                      ready_up,
	input  idl_pkg::search_t          data_s1,
	output logic                      valid_s3,
	input  logic                      ready_dn,
	output logic [idl_pkg::DIST_W-1:0] dist_s3,
	output logic                      beyond_s3
);
	import idl_pkg::*;

	logic [IDX_W-1:0]  prev_idx;
	logic [CAL_W-1:0]  hi;
	logic [CAL_W-1:0]  lo;
	logic [CMP_W-1:0]  diff;
	logic [NUM_W-1:0]  num;
	logic [CAL_W-1:0]  span;
	logic [DIST_W-1:0] base;
	logic              use_frac;

	logic              valid_s2;
	logic [NUM_W-1:0]  num_s2;
	logic [CAL_W-1:0]  span_s2;
	logic [DIST_W-1:0] base_s2;
	logic              use_frac_s2;
	logic              beyond_s2;

	logic [NUM_W-1:0]  mult1;
	logic [NUM_W-1:0]  mult2;
	logic [NUM_W-1:0]  mult3;
	logic [NUM_W-1:0]  mult4;
	logic [FRAC_W-1:0] frac;
	logic [DIST_W-1:0] dist_sum;

	logic              adv_s2;
	logic              adv_s3;

	assign adv_s3   = !valid_s3 || ready_dn;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign ready_up = adv_s2;

	// Neighbors of the bracket, scaled numerator and span.
	always_comb begin
		prev_idx = (data_s1.idx == '0) ? '0 : data_s1.idx - IDX_W'(1);
		hi       = CAL_TABLE[prev_idx];
		lo       = CAL_TABLE[data_s1.idx];
		diff     = CMP_W'(hi) - CMP_W'(data_s1.sample);
		num      = (NUM_W'(diff) << 2) + NUM_W'(diff);
		span     = hi - lo;
		use_frac = data_s1.found && (data_s1.idx != '0);
		priority if (!data_s1.found) begin
			base = SAT_DIST;
		end else if (data_s1.idx == '0) begin
			base = STEP_DIST;
		end else begin
			base = (DIST_W'(data_s1.idx) << 2) + DIST_W'(data_s1.idx);
		end
	end

	// Stage 2 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			num_s2      <= num;
			span_s2     <= span;
			base_s2     <= base;
			use_frac_s2 <= use_frac;
			beyond_s2   <= !data_s1.found;
		end
	end

	// The quotient is below five, so four compares against multiples of the span give it.
	always_comb begin
		mult1 = NUM_W'(span_s2);
		mult2 = NUM_W'(span_s2) << 1;
		mult3 = (NUM_W'(span_s2) << 1) + NUM_W'(span_s2);
		mult4 = NUM_W'(span_s2) << 2;
		frac  = FRAC_W'(num_s2 >= mult1) + FRAC_W'(num_s2 >= mult2)
			+ FRAC_W'(num_s2 >= mult3) + FRAC_W'(num_s2 >= mult4);
		if (use_frac_s2 && (span_s2 != '0)) begin
			dist_sum = base_s2 + DIST_W'(frac);
		end else begin
			dist_sum = base_s2;
		end
	end

	// Stage 3 register, which is also the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			dist_s3   <= dist_sum;
			beyond_s3 <= beyond_s2;
		end
	end

endmodule

// ----- src/ir_distance_linearizer_top.sv -----
// Infrared distance linearizer: each 10-bit sensor reading on the slave stream becomes a
// distance in cm on the master stream, interpolated between calibration points 5 cm apart
// and saturated at 80 cm with tuser set when the reading is at or below the farthest point.
// The block takes one item per clock while the output is not stalled, and each result passes
// through its three register stages (table search, span and numerator, quotient and sum);
// a stalled output holds the pipeline without losing items.
module ir_distance_linearizer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [idl_pkg::IN_TDATA_W-1:0]  s_tdata,  // [9:0] sample, rest zero
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [idl_pkg::OUT_TDATA_W-1:0] m_tdata,  // [6:0] distance_cm, rest zero
	output logic                           m_tuser   // [0] beyond_range
);
	import idl_pkg::*;

	logic              valid_s1;
	logic              ready_s2;
	search_t           data_s1;
	logic [DIST_W-1:0] dist_s3;
	logic              beyond_s3;

	idl_search u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_sample(s_tdata[SAMPLE_BITS-1:0]),
		.valid_s1 (valid_s1),
		.ready_dn (ready_s2),
		.data_s1  (data_s1)
	);

	idl_interp u_interp (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.ready_up (ready_s2),
		.data_s1  (data_s1),
		.valid_s3 (m_tvalid),
		.ready_dn (m_tready),
		.dist_s3  (dist_s3),
		.beyond_s3(beyond_s3)
	);

	assign m_tdata = OUT_TDATA_W'(dist_s3);
	assign m_tuser = beyond_s3;

	// A saturated item always carries the farthest distance.
	a_sat_dist: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> dist_s3 == SAT_DIST)
		else $error("saturated item with wrong distance");

	// An in-range item lies inside the table span.
	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (dist_s3 >= STEP_DIST) && (dist_s3 < SAT_DIST))
		else $error("in-range distance outside the table span");

	// A search result held by a stall stays put.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1 && $stable(data_s1))
		else $error("stage 1 item changed while stalled");

endmodule

// ----- tb/tb_ir_distance_linearizer_top.sv -----
module tb_ir_distance_linearizer_top;

	import idl_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 12;
	localparam int HOLD_CYCLES  = 300;
	localparam int MAX_REPORTS  = 10;
	localparam int PHASE_ITEMS  = 490;

	// Calibration readings at 5, 10, 15, ... cm, kept here for the predictor.
	localparam logic [9:0] SENSOR_CAL [16] = '{
		10'd1023, 10'd730, 10'd570, 10'd450, 10'd390, 10'd340, 10'd300, 10'd260,
		10'd240,  10'd200, 10'd180, 10'd170, 10'd160, 10'd155, 10'd150, 10'd145
	};

	typedef struct packed {
		logic [DIST_W-1:0] distance_cm;
		logic              beyond_range;
	} range_result_t;

	logic                      clk      = 1'b0;
	logic                      arst_n   = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [IN_TDATA_W-1:0]     s_tdata  = '0;  // [9:0] sample, rest zero
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]    m_tdata;        // [6:0] distance_cm, rest zero
	logic                      m_tuser;        // [0] beyond_range

	range_result_t expected_ranges[$];
	int unsigned   gap_pct      = 0;
	int unsigned   stall_pct    = 0;
	int unsigned   hold_left    = 0;
	int unsigned   mismatches   = 0;
	int unsigned   samples_sent = 0;
	int unsigned   ranges_seen  = 0;
	int unsigned   beyond_seen  = 0;

	ir_distance_linearizer_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #HALF_PERIOD clk = ~clk;

	// Expected distance: find the first reading below the sample and interpolate
	// between it and its nearer neighbor.
	function automatic range_result_t linearize(logic [9:0] smp);
		range_result_t r;
		logic          hit;
		int unsigned   hi;
		int unsigned   lo;
		int unsigned   frac;
		r.distance_cm  = DIST_W'(5 * 16);
		r.beyond_range = 1'b1;
		hit = 1'b0;
		for (int i = 0; i < 16; i++) begin
			if (!hit && SENSOR_CAL[i] < smp) begin
				hit = 1'b1;
				r.beyond_range = 1'b0;
				if (i == 0) begin
					r.distance_cm = DIST_W'(5);
				end else begin
					hi   = SENSOR_CAL[i-1];
					lo   = SENSOR_CAL[i];
					frac = (5 * (hi - smp)) / (hi - lo);
					r.distance_cm = DIST_W'(5 * i + frac);
				end
			end
		end
		return r;
	endfunction

	// Random samples lean toward calibration points and the saturated region.
	function automatic logic [9:0] pick_sample();
		int unsigned k = $urandom_range(15);
		int          v;
		case ($urandom_range(3))
			0: begin
				v = int'(SENSOR_CAL[k]) + int'($urandom_range(2)) - 1;
				if (v > 1023)
					v = 1023;
				return 10'(v);
			end
			1: return 10'($urandom_range(160));
			default: return 10'($urandom);
		endcase
	endfunction

	// Offers one sample, with random gaps ahead of it, and books its result once taken.
	task automatic send_sample(logic [9:0] smp);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W-10){1'b0}}, smp};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_ranges.push_back(linearize(smp));
		samples_sent++;
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_ranges.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		logic [9:0] corner [22] = '{
			10'd0, 10'd1023, 10'd1022, 10'd1, 10'd144, 10'd145, 10'd146, 10'd150,
			10'd151, 10'd731, 10'd730, 10'd729, 10'd571, 10'd570, 10'd241, 10'd201,
			10'd200, 10'd300, 10'd512, 10'h2AA, 10'h155, 10'd1000
		};
		gap_pct   <= 0;
		stall_pct <= 0;
		foreach (corner[i])
			send_sample(corner[i]);
		wait_for_drain();
	endtask

	task automatic test_random_phase(int unsigned gaps, int unsigned stalls, int unsigned count);
		gap_pct   <= gaps;
		stall_pct <= stalls;
		repeat (count)
			send_sample(pick_sample());
	endtask

	// The receiver holds off long enough for the pipeline to fill and stall the input.
	task automatic test_backpressure();
		wait_for_drain();
		gap_pct   <= 0;
		stall_pct <= 0;
		hold_left <= HOLD_CYCLES;
		repeat (40)
			send_sample(pick_sample());
	endtask

	// The sender stops until every booked result is back, then resumes.
	task automatic test_drained_pause();
		gap_pct   <= 8;
		stall_pct <= 8;
		repeat (20)
			send_sample(pick_sample());
		wait_for_drain();
		repeat (20)
			send_sample(pick_sample());
	endtask

	// Hold-off counter for the receiver.
	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	// Result checker and receiver stalls.
	always @(posedge clk) begin
		range_result_t exp_range;
		if (arst_n && m_tvalid && m_tready) begin
			ranges_seen++;
			if (expected_ranges.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("Unexpected result: distance %0d beyond %0b",
						m_tdata, m_tuser);
			end else begin
				exp_range = expected_ranges.pop_front();
				if (exp_range.beyond_range)
					beyond_seen++;
				if (m_tdata !== OUT_TDATA_W'(exp_range.distance_cm)) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("distance_cm mismatch: expected %0d, got %0d",
							exp_range.distance_cm, m_tdata);
				end
				if (m_tuser !== exp_range.beyond_range) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("beyond_range mismatch: expected %0b, got %0b",
							exp_range.beyond_range, m_tuser);
				end
			end
		end
		m_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
	end

	initial begin
		int unsigned waited;
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_phase(0, 0, PHASE_ITEMS);
		test_random_phase(74, 0, PHASE_ITEMS);
		test_random_phase(0, 74, PHASE_ITEMS);
		test_random_phase(8, 8, PHASE_ITEMS);
		test_backpressure();
		test_drained_pause();

		// Let the pipeline empty, then keep watching for stray results.
		s_tvalid <= 1'b0;
		waited = 0;
		while (expected_ranges.size() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10)
			@(posedge clk);
		if (expected_ranges.size() != 0) begin
			mismatches++;
			$display("%0d expected results never arrived", expected_ranges.size());
		end

		$display("Sent %0d samples and checked %0d distances, %0d of them saturated.",
			samples_sent, ranges_seen, beyond_seen);
		$display("Covered corner readings, idle and stall mixes, a long output hold-off.");
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Run limit.
	initial begin
		#2000000;
		$display("Timeout waiting for the block");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
